@@ design/c2sa_pkg.sv @@
// Shared types and constants for the Cartesian to spherical angle converter.
`default_nettype none

package c2sa_pkg;

    // Datapath widths after normalisation: the largest magnitude sits in [2^31, 2^32).
    localparam int NORM_W  = 32;
    localparam int SHIFT_W = 5;
    localparam int CORDIC_STEPS = 32;
    // Rotating vector needs headroom for two CORDIC gains and sqrt(2).
    localparam int CVAL_W = 37;
    // Internal binary angle: 2^32 is one full turn, plus sign and margin.
    localparam int ANG_W  = 34;

    typedef logic signed [CVAL_W-1:0] t_cval;
    typedef logic signed [ANG_W-1:0]  t_ang;

    localparam t_ang HALF_TURN    = t_ang'(64'sd2147483648);
    localparam t_ang QUARTER_TURN = t_ang'(64'sd1073741824);

    // CORDIC gain K in Q30.
    localparam logic [30:0] CORDIC_K_Q30 = 31'd1768195363;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

`default_nettype wire

@@ design/c2sa_cordic_step.sv @@
// One registered vectoring CORDIC micro-rotation.
`default_nettype none

module c2sa_cordic_step #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  c2sa_pkg::t_cval i_x,
    input  c2sa_pkg::t_cval i_y,
    input  c2sa_pkg::t_ang  i_a,
    output c2sa_pkg::t_cval o_x,
    output c2sa_pkg::t_cval o_y,
    output c2sa_pkg::t_ang  o_a
);
    import c2sa_pkg::*;

    t_cval r_x, r_y;
    t_ang  r_a;
    t_cval dx, dy;
    t_ang  step_ang;

    assign dx       = i_y >>> STEP;
    assign dy       = i_x >>> STEP;
    assign step_ang = t_ang'({2'b00, ATAN_TAB[STEP]});

    // Rotate toward +x: positive turn only while y is strictly above zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_a <= i_a + step_ang;
            end else begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_a <= i_a - step_ang;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_a = r_a;

endmodule

`default_nettype wire

@@ design/cartesian_to_spherical_angles.sv @@
// Top level: streaming Cartesian vector to polar and azimuth binary angles.
//
//  channel | direction | handshake                   | beat payload
//  --------+-----------+-----------------------------+--------------------------------------
//  in      | sink      | i_in_valid / o_in_ready     | i_x_coord, i_y_coord, i_z_coord
//  out     | source    | o_out_valid / i_out_ready   | o_polar_angle, o_azimuth_angle,
//          |           |                             | o_zero_vector
//  cfg     | sink      | i_cfg_we (no wait)          | i_cfg_wdata -> pole tolerance
//
//  One beat enters per cycle while the pipeline is not held; the path runs through
//  the two 32-step CORDIC pipelines plus the normalise, multiply and result stages.
//  The whole pipeline advances together: it holds when the result register is
//  full and not taken, and bubbles then hold in place as well.
//  Reset (i_rst_n low at a clock edge) clears every valid bit and sets the pole
//  tolerance to 1; payload registers are not reset.
`default_nettype none

module cartesian_to_spherical_angles #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [7:0]                    i_cfg_wdata,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [COORD_WIDTH-1:0] i_z_coord,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ANGLE_WIDTH-1:0]        o_polar_angle,
    output logic [ANGLE_WIDTH-1:0]        o_azimuth_angle,
    output logic                          o_zero_vector
);
    import c2sa_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam logic [32:0]   RND      = 33'd1 << (31 - AW);
    localparam logic [AW-1:0] HALF_OUT = AW'(1) << (AW - 1);

    typedef struct packed {
        logic [NORM_W:0]   p;      // |z| scaled by the CORDIC gain
        logic              nz;
        logic              zero;
        logic              xy_zero;
    } t_side1;

    // Global advance: move everything unless a finished beat is waiting and not taken.
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Configuration register.
    logic [7:0] r_pole_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_tol <= 8'd1;
        end else if (i_cfg_we) begin
            r_pole_tol <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Front end: magnitudes, maximum, shift count, normalise, multiply.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;

    logic [CW-1:0] r1_mx, r1_my, r1_mz;
    logic          r1_nx, r1_ny, r1_nz;
    logic [CW-1:0] r2_mx, r2_my, r2_mz, r2_max;
    logic          r2_nx, r2_ny, r2_nz;
    logic [NORM_W-1:0]  r3_mx, r3_my, r3_mz;
    logic [SHIFT_W-1:0] r3_sh;
    logic          r3_nx, r3_ny, r3_nz, r3_zero, r3_xyz;
    logic [NORM_W-1:0] r4_mx, r4_my, r4_mz;
    logic          r4_nx, r4_ny, r4_nz, r4_zero, r4_xyz;

    logic [CW-1:0] ux, uy, uz;
    assign ux = i_x_coord;
    assign uy = i_y_coord;
    assign uz = i_z_coord;

    logic [CW-1:0] max_xy, max_xyz;
    assign max_xy  = (r1_my > r1_mx) ? r1_my : r1_mx;
    assign max_xyz = (r1_mz > max_xy) ? r1_mz : max_xy;

    // Leading-one position of the largest magnitude.
    logic [NORM_W-1:0]  max_ext;
    logic [SHIFT_W-1:0] msb;
    assign max_ext = NORM_W'(r2_max);
    always_comb begin
        msb = '0;
        for (int b = 0; b < NORM_W; b++) begin
            if (max_ext[b]) msb = SHIFT_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // take magnitudes and signs
            r1_mx <= ux[CW-1] ? (~ux + 1'b1) : ux;
            r1_my <= uy[CW-1] ? (~uy + 1'b1) : uy;
            r1_mz <= uz[CW-1] ? (~uz + 1'b1) : uz;
            r1_nx <= ux[CW-1];
            r1_ny <= uy[CW-1];
            r1_nz <= uz[CW-1];
            // pick the largest
            r2_mx  <= r1_mx;
            r2_my  <= r1_my;
            r2_mz  <= r1_mz;
            r2_max <= max_xyz;
            r2_nx  <= r1_nx;
            r2_ny  <= r1_ny;
            r2_nz  <= r1_nz;
            // shift count so the largest lands in [2^31, 2^32)
            r3_mx   <= NORM_W'(r2_mx);
            r3_my   <= NORM_W'(r2_my);
            r3_mz   <= NORM_W'(r2_mz);
            r3_sh   <= SHIFT_W'(NORM_W - 1) - msb;
            r3_nx   <= r2_nx;
            r3_ny   <= r2_ny;
            r3_nz   <= r2_nz;
            r3_zero <= (r2_max == '0);
            r3_xyz  <= (r2_mx == '0) && (r2_my == '0);
            // normalise
            r4_mx   <= r3_mx << r3_sh;
            r4_my   <= r3_my << r3_sh;
            r4_mz   <= r3_mz << r3_sh;
            r4_nx   <= r3_nx;
            r4_ny   <= r3_ny;
            r4_nz   <= r3_nz;
            r4_zero <= r3_zero;
            r4_xyz  <= r3_xyz;
        end
    end

    // ------------------------------------------------------------------
    // First CORDIC: azimuth of (x, y) and gain-scaled radius.
    // ------------------------------------------------------------------
    t_cval x1 [CORDIC_STEPS+1];
    t_cval y1 [CORDIC_STEPS+1];
    t_ang  a1 [CORDIC_STEPS+1];
    logic   r_v1c  [CORDIC_STEPS+1];
    t_side1 r_sb1  [CORDIC_STEPS+1];

    t_cval r_x1i, r_y1i;
    t_ang  r_a1i;
    logic [62:0] r_prod;

    t_cval mx_s, my_s;
    assign mx_s = t_cval'({{(CVAL_W-NORM_W){1'b0}}, r4_mx});
    assign my_s = t_cval'({{(CVAL_W-NORM_W){1'b0}}, r4_my});

    // Left half-plane: negate the vector and start from half a turn.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1i  <= mx_s;
            r_y1i  <= (r4_ny ^ r4_nx) ? -my_s : my_s;
            r_a1i  <= r4_nx ? HALF_TURN : t_ang'(0);
            r_prod <= r4_mz * CORDIC_K_Q30;
        end
    end

    assign x1[0] = r_x1i;
    assign y1[0] = r_y1i;
    assign a1[0] = r_a1i;

    logic [63:0] prod_rnd;
    assign prod_rnd = {1'b0, r_prod} + 64'd536870912;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) r_v1c[k] <= 1'b0;
        end else if (en) begin
            r_v1c[0] <= r_v4;
            for (int k = 0; k < CORDIC_STEPS; k++) r_v1c[k+1] <= r_v1c[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1[0] <= '{p: '0, nz: r4_nz, zero: r4_zero, xy_zero: r4_xyz};
            // round the gain product into the sideband on its way past
            r_sb1[1] <= '{p: prod_rnd[30 +: NORM_W+1], nz: r_sb1[0].nz,
                          zero: r_sb1[0].zero, xy_zero: r_sb1[0].xy_zero};
            for (int k = 1; k < CORDIC_STEPS; k++) r_sb1[k+1] <= r_sb1[k];
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic1
        c2sa_cordic_step #(.STEP(k)) u_step (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (x1[k]),
            .i_y   (y1[k]),
            .i_a   (a1[k]),
            .o_x   (x1[k+1]),
            .o_y   (y1[k+1]),
            .o_a   (a1[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Second CORDIC: polar angle = atan2(K*r, K*z).
    // ------------------------------------------------------------------
    t_cval x2 [CORDIC_STEPS+1];
    t_cval y2 [CORDIC_STEPS+1];
    t_ang  a2 [CORDIC_STEPS+1];
    logic          r_v2c   [CORDIC_STEPS+1];
    logic [AW-1:0] r_az2   [CORDIC_STEPS+1];
    logic          r_zero2 [CORDIC_STEPS+1];

    t_cval r_x2i, r_y2i;
    t_ang  r_a2i;

    t_side1 sb_end;
    t_cval  zk, xr;
    logic [32:0]  az_sum;
    assign sb_end = r_sb1[CORDIC_STEPS];
    assign xr     = x1[CORDIC_STEPS];
    assign zk     = sb_end.nz ? -t_cval'({4'b0, sb_end.p}) : t_cval'({4'b0, sb_end.p});
    assign az_sum = {1'b0, a1[CORDIC_STEPS][31:0]} + RND;

    // Negative z: turn by minus a quarter and start from a quarter turn.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (zk < 0) begin
                r_x2i <= xr;
                r_y2i <= -zk;
                r_a2i <= QUARTER_TURN;
            end else begin
                r_x2i <= zk;
                r_y2i <= xr;
                r_a2i <= t_ang'(0);
            end
            r_az2[0]   <= sb_end.xy_zero ? '0 : az_sum[31 -: AW];
            r_zero2[0] <= sb_end.zero;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_az2[k+1]   <= r_az2[k];
                r_zero2[k+1] <= r_zero2[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) r_v2c[k] <= 1'b0;
        end else if (en) begin
            r_v2c[0] <= r_v1c[CORDIC_STEPS];
            for (int k = 0; k < CORDIC_STEPS; k++) r_v2c[k+1] <= r_v2c[k];
        end
    end

    assign x2[0] = r_x2i;
    assign y2[0] = r_y2i;
    assign a2[0] = r_a2i;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic2
        c2sa_cordic_step #(.STEP(k)) u_step (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (x2[k]),
            .i_y   (y2[k]),
            .i_a   (a2[k]),
            .o_x   (x2[k+1]),
            .o_y   (y2[k+1]),
            .o_a   (a2[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Result: clamp, round, pole test, zero vector.
    // ------------------------------------------------------------------
    t_ang          pa, pa_clamp;
    logic [32:0]   polar_sum;
    logic [AW-1:0] polar_rnd, polar;
    logic          near_pole;

    assign pa = a2[CORDIC_STEPS];
    always_comb begin
        if (pa < 0) begin
            pa_clamp = '0;
        end else if (pa > HALF_TURN) begin
            pa_clamp = HALF_TURN;
        end else begin
            pa_clamp = pa;
        end
    end
    assign polar_sum = {1'b0, pa_clamp[31:0]} + RND;
    assign polar_rnd = polar_sum[31 -: AW];
    assign polar     = (polar_rnd > HALF_OUT) ? HALF_OUT : polar_rnd;
    assign near_pole = (polar < AW'(r_pole_tol)) || ((HALF_OUT - polar) < AW'(r_pole_tol));

    logic          r_out_v;
    logic [AW-1:0] r_polar, r_azim;
    logic          r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v2c[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_zero2[CORDIC_STEPS]) begin
                r_polar <= '0;
                r_azim  <= '0;
                r_zero  <= 1'b1;
            end else begin
                r_polar <= polar;
                r_azim  <= near_pole ? '0 : r_az2[CORDIC_STEPS];
                r_zero  <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_polar_angle   = r_polar;
    assign o_azimuth_angle = r_azim;
    assign o_zero_vector   = r_zero;

endmodule

`default_nettype wire

@@ design/c2sa_checker.sv @@
// Port-level checker for the angle converter, bound to the top level.
`default_nettype none

module c2sa_checker #(
    parameter int ANGLE_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [ANGLE_WIDTH-1:0] o_polar_angle,
    input logic [ANGLE_WIDTH-1:0] o_azimuth_angle,
    input logic                   o_zero_vector
);
    localparam logic [ANGLE_WIDTH-1:0] HALF = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

    // a zero vector carries zero angles
    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_vector |-> o_polar_angle == '0 && o_azimuth_angle == '0)
        else $error("zero vector beat with non-zero angles");

    a_polar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_polar_angle <= HALF)
        else $error("polar angle beyond half a turn");

    // an empty or draining result stage never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled while output is free");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_polar_angle)
            && $stable(o_azimuth_angle) && $stable(o_zero_vector))
        else $error("stalled output beat changed");

endmodule

bind cartesian_to_spherical_angles c2sa_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_c2sa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_polar_angle   (o_polar_angle),
    .o_azimuth_angle (o_azimuth_angle),
    .o_zero_vector   (o_zero_vector)
);

`default_nettype wire
